// ===== sv/frustum_sphere_cull_top_assert.svh =====
// Assertion helpers for the culling block. Both expect clk_i and rst_ni in scope.
`ifndef FRUSTUM_SPHERE_CULL_TOP_ASSERT_SVH
`define FRUSTUM_SPHERE_CULL_TOP_ASSERT_SVH

// Same-cycle implication.
`define FSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fsc_pkg.sv =====
package fsc_pkg;

  localparam int VALUE_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_PLANES = 6;
  localparam int ACC_W      = 64;
  // plane row terms are one bit wider than a value
  localparam int MAG_W      = VALUE_W + 1;
  // the largest normal magnitude is brought into [2^(NORM_W-1), 2^NORM_W)
  localparam int NORM_W     = 30;
  localparam int DIVIDEND_W = MAG_W + FRAC_BITS;
  localparam int DIVISOR_W  = 32;

  typedef enum logic [1:0] {
    CMD_LOAD_PROJ = 2'd0,
    CMD_LOAD_MV   = 2'd1,
    CMD_EXTRACT   = 2'd2,
    CMD_TEST      = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]                command;
    logic [3:0]                elem_index;
    logic signed [VALUE_W-1:0] elem_value;
    logic signed [VALUE_W-1:0] center_x;
    logic signed [VALUE_W-1:0] center_y;
    logic signed [VALUE_W-1:0] center_z;
    logic [VALUE_W-2:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic                      visible;
    logic signed [VALUE_W-1:0] distance;
  } out_item_t;

  typedef logic [3:0][VALUE_W-1:0] row_t;

  localparam logic signed [ACC_W-1:0] VAL_MAX =
    {{(ACC_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] VAL_MIN = ~VAL_MAX;

  function automatic logic [VALUE_W-1:0] sat_value(input logic signed [ACC_W-1:0] v);
    logic [VALUE_W-1:0] r;
    if (v > VAL_MAX) r = VAL_MAX[VALUE_W-1:0];
    else if (v < VAL_MIN) r = VAL_MIN[VALUE_W-1:0];
    else r = v[VALUE_W-1:0];
    return r;
  endfunction

endpackage

// ===== sv/fsc_div.sv =====
module fsc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [fsc_pkg::DIVIDEND_W-1:0]    dividend_i,
  input  logic [fsc_pkg::DIVISOR_W-1:0]     divisor_i,
  output logic                              done_o,
  output logic [fsc_pkg::DIVIDEND_W-1:0]    quotient_o
);
  import fsc_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                   busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]   rem_q, rem_d, dvs_q, dvs_d;
  logic [DIVIDEND_W-1:0]  quo_q, quo_d;
  logic [DIVISOR_W:0]     trial, diff;
  logic                   ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/frustum_sphere_cull_top.sv =====
// Channel | Handshake                        | Payload
// input   | in_valid_i / in_ready_o          | in_data_i  (fsc_pkg::in_item_t)
// output  | out_valid_o / out_ready_i        | out_data_o (fsc_pkg::out_item_t)
//
// Loads write one matrix element and go straight to write-back. A sphere test runs
// six planes of three products and a reject check on the shared 32x32 multiplier,
// plus accept and write-back; a reject ends it early. Extraction runs the matrix
// product, then per plane the row pass, the normalizing shifts, a 32-step square root
// and four divisions on the serial divider; a plane with an all-zero normal is cleared.
// Reset clears matrices and planes to zero; in_ready_o is low while an item is
// in work, and one finished result may wait in the output register.
module frustum_sphere_cull_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fsc_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fsc_pkg::out_item_t   out_data_o
);
  import fsc_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_MM    = 11'b00000000010,
    ST_ROW   = 11'b00000000100,
    ST_NORM  = 11'b00000001000,
    ST_SQ    = 11'b00000010000,
    ST_SQRT  = 11'b00000100000,
    ST_DIVGO = 11'b00001000000,
    ST_DIVW  = 11'b00010000000,
    ST_DSH   = 11'b00100000000,
    ST_TEST  = 11'b01000000000,
    ST_FIN   = 11'b10000000000
  } state_e;

  state_e                  state_q, state_d;
  logic [2:0]              k_q, k_d, p_q, p_d;
  logic [3:0]              el_q, el_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [63:0]             prod_mag_q;
  logic                    prod_neg_q;
  logic [VALUE_W-1:0]      pj_q [16], pj_d [16], mv_q [16], mv_d [16];
  row_t                    clip_q [4], clip_d [4];
  row_t                    pl_q [NUM_PLANES], pl_d [NUM_PLANES];
  logic [MAG_W-1:0]        mag_q [4], mag_d [4];
  logic [3:0]              sgn_q, sgn_d;
  logic [MAG_W-1:0]        mmax_q, mmax_d;
  logic signed [5:0]       sh_q, sh_d;
  logic [63:0]             sq_v_q, sq_v_d, sq_res_q, sq_res_d, sq_bit_q, sq_bit_d;
  logic [DIVISOR_W-1:0]    t_q, t_d;
  logic [63:0]             v_q, v_d;
  in_item_t                in_q, in_d;
  out_item_t               res_q, res_d, out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic signed [VALUE_W-1:0] mul_a, mul_b;
  logic [VALUE_W-1:0]        ua, ub;
  logic signed [ACC_W-1:0]   pv, fx_ext, sum, q64, dval;
  logic [63:0]               sq_try;
  logic                      div_start, div_done;
  logic [DIVIDEND_W-1:0]     div_q;
  logic [1:0]                rr, cc, col;
  logic signed [MAG_W-1:0]   w_t, o_t, raw;
  logic [MAG_W-1:0]          raw_mag;
  row_t                      crow, prow;

  fsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag_q[k_q[1:0]], {FRAC_BITS{1'b0}}}),
    .divisor_i  (t_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // shared multiplier: magnitude product registered, sign alongside
  assign ua     = mul_a[VALUE_W-1] ? VALUE_W'(-mul_a) : mul_a;
  assign ub     = mul_b[VALUE_W-1] ? VALUE_W'(-mul_b) : mul_b;
  assign fx_ext = $signed({{FRAC_BITS{1'b0}}, prod_mag_q[63:FRAC_BITS]});
  assign pv     = prod_neg_q ? -fx_ext : fx_ext;
  assign q64    = $signed({{(ACC_W-DIVIDEND_W){1'b0}}, div_q});
  assign sq_try = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i) begin
    prod_mag_q <= ua * ub;
    prod_neg_q <= mul_a[VALUE_W-1] ^ mul_b[VALUE_W-1];
  end

  // plane p: column 3 minus or plus column p/2
  assign rr      = el_q[1:0];
  assign cc      = el_q[1:0];
  assign col     = p_q[2:1];
  assign crow    = clip_q[rr];
  assign w_t     = $signed({crow[3][VALUE_W-1], crow[3]});
  assign o_t     = $signed({crow[col][VALUE_W-1], crow[col]});
  assign raw     = (p_q == 3'd0 || p_q == 3'd3 || p_q == 3'd4) ? w_t - o_t : w_t + o_t;
  assign raw_mag = raw[MAG_W-1] ? MAG_W'(-raw) : raw;
  assign prow    = pl_q[p_q];
  assign dval    = acc_q + pv;
  assign sum     = dval + $signed({{(ACC_W-VALUE_W+1){1'b0}}, in_q.radius});

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    p_d         = p_q;
    el_d        = el_q;
    acc_d       = acc_q;
    pj_d        = pj_q;
    mv_d        = mv_q;
    clip_d      = clip_q;
    pl_d        = pl_q;
    mag_d       = mag_q;
    sgn_d       = sgn_q;
    mmax_d      = mmax_q;
    sh_d        = sh_q;
    sq_v_d      = sq_v_q;
    sq_res_d    = sq_res_q;
    sq_bit_d    = sq_bit_q;
    t_d         = t_q;
    v_d         = v_q;
    in_d        = in_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_d  = in_data_i;
          res_d = '0;
          k_d   = '0;
          p_d   = '0;
          el_d  = '0;
          case (cmd_e'(in_data_i.command))
            CMD_LOAD_PROJ: begin
              pj_d[in_data_i.elem_index] = in_data_i.elem_value;
              state_d = ST_FIN;
            end
            CMD_LOAD_MV: begin
              mv_d[in_data_i.elem_index] = in_data_i.elem_value;
              state_d = ST_FIN;
            end
            CMD_EXTRACT: state_d = ST_MM;
            CMD_TEST:    state_d = ST_TEST;
            default:     state_d = ST_FIN;
          endcase
        end
      end

      // clip[r][c] = sum over k of mv[r][k] * pj[k][c], one product per cycle
      ST_MM: begin
        mul_a = mv_q[{el_q[3:2], k_q[1:0]}];
        mul_b = pj_q[{k_q[1:0], el_q[1:0]}];
        acc_d = (k_q == 3'd0) ? '0 : dval;
        if (k_q == 3'd4) begin
          clip_d[el_q[3:2]][cc] = sat_value(dval);
          k_d  = '0;
          el_d = el_q + 1'b1;
          if (el_q == 4'd15) begin
            state_d = ST_ROW;
            p_d     = '0;
            mmax_d  = '0;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      ST_ROW: begin
        mag_d[rr] = raw_mag;
        sgn_d[rr] = raw[MAG_W-1];
        if (rr != 2'd3 && raw_mag > mmax_q) mmax_d = raw_mag;
        el_d = el_q + 1'b1;
        if (rr == 2'd3) begin
          el_d = '0;
          sh_d = '0;
          if (mmax_q == '0) begin
            pl_d[p_q] = '0;
            if (p_q == 3'(NUM_PLANES - 1)) begin
              state_d = ST_FIN;
            end else begin
              p_d     = p_q + 1'b1;
              mmax_d  = '0;
            end
          end else begin
            state_d = ST_NORM;
          end
        end
      end

      // one bit of shift per cycle until the largest normal term has NORM_W bits
      ST_NORM: begin
        k_d = '0;
        if (mmax_q[MAG_W-1:NORM_W] != '0) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
          mmax_d = mmax_q >> 1;
          sh_d   = sh_q + 6'sd1;
        end else if (!mmax_q[NORM_W-1]) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
          mmax_d = mmax_q << 1;
          sh_d   = sh_q - 6'sd1;
        end else begin
          state_d = ST_SQ;
        end
      end

      ST_SQ: begin
        mul_a = $signed({{(VALUE_W-NORM_W){1'b0}}, mag_q[k_q[1:0]][NORM_W-1:0]});
        mul_b = mul_a;
        acc_d = (k_q == 3'd0) ? '0 : $signed(acc_q + prod_mag_q);
        if (k_q == 3'd3) begin
          sq_v_d   = acc_q + prod_mag_q;
          sq_res_d = '0;
          sq_bit_d = 64'd1 << 62;
          state_d  = ST_SQRT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      ST_SQRT: begin
        if (sq_v_q >= sq_try) begin
          sq_v_d   = sq_v_q - sq_try;
          sq_res_d = (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_d = sq_res_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
        if (sq_bit_q[0]) begin
          t_d     = (sq_res_d[DIVISOR_W-1:0] == '0) ? DIVISOR_W'(1) : sq_res_d[DIVISOR_W-1:0];
          k_d     = '0;
          state_d = ST_DIVGO;
        end
      end

      ST_DIVGO: begin
        div_start = 1'b1;
        state_d   = ST_DIVW;
      end

      ST_DIVW: begin
        if (div_done) begin
          if (k_q != 3'd3) begin
            pl_d[p_q][k_q[1:0]] = sat_value(sgn_q[k_q[1:0]] ? -q64 : q64);
            k_d     = k_q + 1'b1;
            state_d = ST_DIVGO;
          end else begin
            v_d     = q64;
            state_d = ST_DSH;
          end
        end
      end

      // undo the normalizing shift on the offset term
      ST_DSH: begin
        if (sh_q > 6'sd0) begin
          v_d  = v_q >> 1;
          sh_d = sh_q - 6'sd1;
        end else if (sh_q < 6'sd0) begin
          v_d  = v_q << 1;
          sh_d = sh_q + 6'sd1;
        end else begin
          pl_d[p_q][3] = sat_value(sgn_q[3] ? -$signed(v_q) : $signed(v_q));
          el_d = '0;
          if (p_q == 3'(NUM_PLANES - 1)) begin
            state_d = ST_FIN;
          end else begin
            p_d     = p_q + 1'b1;
            mmax_d  = '0;
            state_d = ST_ROW;
          end
        end
      end

      // per plane: three products, then the reject check
      ST_TEST: begin
        mul_a = prow[k_q[1:0]];
        case (k_q[1:0])
          2'd0:    mul_b = in_q.center_x;
          2'd1:    mul_b = in_q.center_y;
          default: mul_b = in_q.center_z;
        endcase
        acc_d = (k_q == 3'd0) ? $signed({{(ACC_W-VALUE_W){prow[3][VALUE_W-1]}}, prow[3]})
                              : dval;
        if (k_q == 3'd3) begin
          k_d = '0;
          if (sum <= 0) begin
            state_d = ST_FIN;
          end else if (p_q == 3'(NUM_PLANES - 1)) begin
            res_d.visible  = 1'b1;
            res_d.distance = sat_value(sum);
            state_d        = ST_FIN;
          end else begin
            p_d = p_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      p_q         <= '0;
      el_q        <= '0;
      for (int i = 0; i < 16; i++) begin
        pj_q[i] <= '0;
        mv_q[i] <= '0;
      end
      for (int i = 0; i < NUM_PLANES; i++) pl_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      p_q         <= p_d;
      el_q        <= el_d;
      pj_q        <= pj_d;
      mv_q        <= mv_d;
      pl_q        <= pl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    clip_q   <= clip_d;
    mag_q    <= mag_d;
    sgn_q    <= sgn_d;
    mmax_q   <= mmax_d;
    sh_q     <= sh_d;
    sq_v_q   <= sq_v_d;
    sq_res_q <= sq_res_d;
    sq_bit_q <= sq_bit_d;
    t_q      <= t_d;
    v_q      <= v_d;
    in_q     <= in_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "frustum_sphere_cull_top_assert.svh"

  `FSC_ASSERT_NXT(a_busy_after_transfer, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `FSC_ASSERT_IMP(a_div_done_waiting, div_done, state_q == ST_DIVW, "divider done out of sequence")
  `FSC_ASSERT_IMP(a_norm_range, state_q == ST_SQ && k_q == 3'd0, mmax_q[MAG_W-1:NORM_W] == '0 && mmax_q[NORM_W-1], "normal not normalized")
  `FSC_ASSERT_IMP(a_visible_positive, out_valid_o && out_data_o.visible, out_data_o.distance > 0, "visible with non-positive distance")

endmodule

// ===== tb/tb_frustum_sphere_cull_top.sv =====
`timescale 1ns / 1ps

module tb_frustum_sphere_cull_top;
  import fsc_pkg::*;

  localparam longint unsigned MAG_CAP = 64'd1 << 60;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  frustum_sphere_cull_top dut (.*);

  // predictor state
  longint    proj_m[16];
  longint    mv_m[16];
  longint    plane_c[24];
  out_item_t cull_q[$];
  int        n_err;
  int        n_sent;
  int        idle_in;
  int        idle_out;
  stim_row_t dir_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #144_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint signed_cap(longint unsigned m, bit neg);
    if (m > MAG_CAP) m = MAG_CAP;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    p = 128'(mag_of(a)) * 128'(mag_of(b));
    p = p >> FRAC_BITS;
    if (p > 128'(MAG_CAP)) p = 128'(MAG_CAP);
    return signed_cap(p[63:0], (a < 0) != (b < 0));
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void norm_plane(int p, longint r[4]);
    longint unsigned mg[4], n[3], m, t, q, rem, v;
    int e, s;
    m = 0;
    for (int i = 0; i < 4; i++) mg[i] = mag_of(r[i]);
    for (int i = 0; i < 3; i++) if (mg[i] > m) m = mg[i];
    if (m == 0) begin
      for (int i = 0; i < 4; i++) plane_c[p*4+i] = 0;
      return;
    end
    e = 0;
    while (e < 63 && (m >> e) != 0) e++;
    s = e - 30;
    for (int i = 0; i < 3; i++) n[i] = s > 0 ? mg[i] >> s : mg[i] << (-s);
    t = sqrt_floor(n[0]*n[0] + n[1]*n[1] + n[2]*n[2]);
    if (t == 0) t = 1;
    for (int i = 0; i < 3; i++)
      plane_c[p*4+i] = sat32(signed_cap((n[i] << FRAC_BITS) / t, r[i] < 0));
    q = mg[3] / t;
    rem = mg[3] % t;
    if (q > (MAG_CAP >> FRAC_BITS)) v = MAG_CAP;
    else v = (q << FRAC_BITS) + ((rem << FRAC_BITS) / t);
    if (s > 0) begin
      v >>= s;
    end else if (s < 0) begin
      if (v > (MAG_CAP >> (-s))) v = MAG_CAP;
      else v <<= (-s);
    end
    plane_c[p*4+3] = sat32(signed_cap(v, r[3] < 0));
  endfunction

  function automatic void extract_frustum();
    longint clip[16], raw[4], acc;
    int col_sel[6], neg_sel[6];
    col_sel = '{0, 0, 1, 1, 2, 2};
    neg_sel = '{1, 0, 0, 1, 1, 0};
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += fx_mul(mv_m[4*r+k], proj_m[4*k+c]);
        clip[4*r+c] = sat32(acc);
      end
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int r = 0; r < 4; r++)
        raw[r] = neg_sel[p] ? clip[4*r+3] - clip[4*r+col_sel[p]]
                            : clip[4*r+3] + clip[4*r+col_sel[p]];
      norm_plane(p, raw);
    end
  endfunction

  function automatic out_item_t cull_predict(in_item_t it);
    out_item_t o;
    longint d, rad;
    bit pass;
    o = '0;
    case (cmd_e'(it.command))
      CMD_LOAD_PROJ: proj_m[it.elem_index] = longint'(it.elem_value);
      CMD_LOAD_MV:   mv_m[it.elem_index] = longint'(it.elem_value);
      CMD_EXTRACT:   extract_frustum();
      default: begin
        rad = longint'({1'b0, it.radius});
        pass = 1'b1;
        d = 0;
        for (int p = 0; p < NUM_PLANES && pass; p++) begin
          d = fx_mul(plane_c[p*4], longint'(it.center_x))
            + fx_mul(plane_c[p*4+1], longint'(it.center_y))
            + fx_mul(plane_c[p*4+2], longint'(it.center_z)) + plane_c[p*4+3];
          if (d <= -rad) pass = 1'b0;
        end
        if (pass) begin
          o.visible = 1'b1;
          o.distance = 32'(sat32(d + rad));
        end
      end
    endcase
    return o;
  endfunction

  function automatic in_item_t mk_item(cmd_e c, int idx, int val, int x, int y, int z,
                                       int r);
    in_item_t it;
    it.command = c;
    it.elem_index = 4'(idx);
    it.elem_value = val;
    it.center_x = x;
    it.center_y = y;
    it.center_z = z;
    it.radius = 31'(r);
    return it;
  endfunction

  function automatic in_item_t rand_item();
    logic [223:0] bits_v;
    bits_v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits_v[$bits(in_item_t)-1:0];
  endfunction

  function automatic void add_row(in_item_t it, bit typed = 0, bit vis = 0,
                                  int exp_dist = 0);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.res.visible = vis;
    row.res.distance = exp_dist;
    dir_rows.push_back(row);
  endfunction

  function automatic int small_val();
    return $urandom_range(0, 2**19) - 2**18;
  endfunction

  function automatic int coord_val();
    return ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2**24) - 2**23;
  endfunction

  function automatic int radius_val();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(0, 2**22);
    endcase
  endfunction

  task automatic send(in_item_t it, bit typed = 0, out_item_t typed_res = '0);
    out_item_t exp_res;
    while ($urandom_range(0, 99) < idle_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    exp_res = cull_predict(it);
    cull_q.push_back(typed ? typed_res : exp_res);
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (cull_q.size() != 0) @(posedge clk_i);
  endtask

  // one frame: most matrix elements reloaded, extract, a run of sphere tests; some noise
  task automatic run_frame();
    in_item_t it;
    int order[32];
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        it = rand_item();
        send(it);
      end
      return;
    end
    foreach (order[i]) order[i] = i;
    order.shuffle();
    foreach (order[i]) begin
      it = rand_item();
      it.command = order[i] < 16 ? CMD_LOAD_PROJ : CMD_LOAD_MV;
      it.elem_index = 4'(order[i] % 16);
      it.elem_value = ($urandom_range(0, 19) == 0) ? $urandom : small_val();
      // diagonal biased toward one so many spheres survive
      if (it.elem_index % 5 == 0 && $urandom_range(0, 1)) it.elem_value = 32'h1_0000;
      if ($urandom_range(0, 15) != 0) send(it);
    end
    it = rand_item();
    it.command = CMD_EXTRACT;
    send(it);
    repeat ($urandom_range(8, 30)) begin
      it = mk_item(CMD_TEST, $urandom, $urandom, coord_val(), coord_val(), coord_val(),
                   radius_val());
      send(it);
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= idle_out);
  end

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cull_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result transfer: %p", out_data_o);
      end else begin
        e = cull_q.pop_front();
        if (out_data_o.visible !== e.visible || out_data_o.distance !== e.distance) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp vis %0b dist %0d, got vis %0b dist %0d",
                     e.visible, e.distance, out_data_o.visible, out_data_o.distance);
        end
      end
    end
  end

  initial begin
    int wait_cyc;
    n_err = 0;
    n_sent = 0;
    idle_in = 7;
    idle_out = 88;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    for (int i = 0; i < 16; i++) begin
      proj_m[i] = 0;
      mv_m[i] = 0;
    end
    for (int i = 0; i < 24; i++) plane_c[i] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero planes: a zero radius is rejected, any other radius passes with d = 0
    add_row(mk_item(CMD_TEST, 0, 0, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk_item(CMD_TEST, 15, -1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1),
            1, 1, 1);
    add_row(mk_item(CMD_TEST, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7fff_ffff), 1, 1, 32'h7fff_ffff);
    add_row(mk_item(CMD_LOAD_PROJ, 0, 32'h7fff_ffff, -1, -1, -1, 32'h7fff_ffff), 1, 0, 0);
    add_row(mk_item(CMD_LOAD_MV, 15, 32'h8000_0000, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk_item(CMD_EXTRACT, 0, 0, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk_item(CMD_TEST, 0, 0, 32'h1_0000, 0, 0, 32'h1_0000));
    for (int i = 0; i < 4; i++) begin
      add_row(mk_item(CMD_LOAD_PROJ, i * 5, 32'h1_0000, 0, 0, 0, 0), 1, 0, 0);
      add_row(mk_item(CMD_LOAD_MV, i * 5, 32'h1_0000, 0, 0, 0, 0), 1, 0, 0);
    end
    add_row(mk_item(CMD_EXTRACT, 0, 0, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk_item(CMD_TEST, 0, 0, 0, 0, 0, 32'h8000));
    add_row(mk_item(CMD_TEST, 0, 0, 32'h50_0000, 0, 0, 32'h1_0000));
    add_row(mk_item(CMD_TEST, 0, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff));
    add_row(mk_item(CMD_TEST, 0, 0, 32'h8000_0000, 32'h8000_0000, 0, 32'h7fff_ffff));
    add_row(mk_item(CMD_TEST, 0, 0, 0, 32'h2_0000, 0, 0));
    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    drain();
    for (int ph = 0; ph < 3; ph++) begin
      idle_in = (ph == 0) ? 7 : (ph == 1) ? 88 : 0;
      idle_out = (ph == 0) ? 88 : (ph == 1) ? 7 : 0;
      while (n_sent < 620 * (ph + 1)) begin
        run_frame();
        if ($urandom_range(0, 7) == 0) drain();
      end
    end

    in_valid_i <= 1'b0;
    wait_cyc = 0;
    while (cull_q.size() != 0 && wait_cyc < 200_000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (100) @(posedge clk_i);
    if (n_err == 0 && cull_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
